>>> rtl/cas_pkg.sv
// shared types and constants for the cave smoothing step
package cas_pkg;

    localparam int ROW_W = 16;
    localparam int COL_W = 7;

    // input transaction kind
    typedef enum logic {
        FUNC_PUSH  = 1'b0,
        FUNC_FLUSH = 1'b1
    } t_func;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_GRID_WIDTH         = 2'd0,
        CFG_GRID_HEIGHT        = 2'd1,
        CFG_NEIGHBOR_THRESHOLD = 2'd2
    } t_cfg_idx;

    // one classified cell passed from the front end to the back end
    typedef struct packed {
        logic [2:0]       col_bits;  // bit0 top, bit1 middle, bit2 bottom row
        logic             emit;
        logic             ic_zero;
        logic             cc_zero;
        logic             last;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_op;

endpackage

>>> rtl/cas_ram.sv
// generic single write port, single read port ram with registered read
module cas_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/cas_front.sv
// front end: scan counters, line store access and classification of each cell
module cas_front import cas_pkg::*; #(
    parameter int MAX_WIDTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_func,
    input  logic        i_cell_is_water,
    output logic        o_stall,
    input  logic [7:0]  i_grid_width,
    input  logic [15:0] i_grid_height,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_op         o_q_op
);

    localparam int    CW         = $clog2(MAX_WIDTH);
    localparam int    EW         = (CW + 1 > 8) ? CW + 1 : 8;

    logic [EW-1:0]      gw_ext;
    logic [EW-1:0]      w_eff;
    logic [EW-1:0]      wm1_full;
    logic [CW-1:0]      wm1;
    logic [15:0]        h_eff;
    logic [16:0]        h_ext;

    logic [16:0]        r_ir, n_ir;
    logic [CW-1:0]      r_ic, n_ic;

    logic               acc, in_grid, drop, go;
    logic               ir_ge1, ir_ge2, ic_zero, col_wrap;
    logic [16:0]        cr;
    logic [CW-1:0]      cc;
    logic [CW+6:0]      cc_ext;
    logic               emit, last;

    logic               r_f_vld;
    logic [CW-1:0]      r_f_slot;
    logic               r_f_ftop, r_f_fmid, r_f_bot;
    logic               r_f_emit, r_f_ic0, r_f_cc0, r_f_last;
    logic [ROW_W-1:0]   r_f_row;
    logic [COL_W-1:0]   r_f_col;
    logic               r_f_byp;
    logic [1:0]         r_f_bypd;

    logic               f_move;
    logic [1:0]         ram_rd, line;
    logic               f_top, f_mid;
    logic [1:0]         wdata;

    // effective grid size
    assign gw_ext   = EW'(i_grid_width);
    assign w_eff    = (gw_ext == '0) ? EW'(1) :
                      (gw_ext > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : gw_ext;
    assign wm1_full = w_eff - EW'(1);
    assign wm1      = wm1_full[CW-1:0];
    assign h_eff    = (i_grid_height == '0) ? 16'd1 : i_grid_height;
    assign h_ext    = {1'b0, h_eff};

    assign f_move  = r_f_vld && !i_q_full;
    assign o_stall = r_f_vld && i_q_full;
    assign acc     = i_valid && !o_stall;

    // flush ticks inside the grid change nothing
    assign in_grid = r_ir < h_ext;
    assign drop    = (i_func == FUNC_FLUSH) && in_grid;
    assign go      = acc && !drop;

    assign ir_ge1  = r_ir != '0;
    assign ir_ge2  = r_ir >= 17'd2;
    assign ic_zero = r_ic == '0;
    assign cr      = ic_zero ? (r_ir - 17'd2) : (r_ir - 17'd1);
    assign cc      = ic_zero ? wm1 : (r_ic - CW'(1));
    assign cc_ext  = {7'd0, cc};
    assign emit    = (ic_zero ? ir_ge2 : ir_ge1) && (cr < h_ext);
    assign last    = emit && (cr == h_ext - 17'd1) && (EW'(cc) == wm1_full);
    assign col_wrap = (EW'(r_ic) + EW'(1)) >= w_eff;

    always_comb begin
        n_ir = r_ir;
        n_ic = r_ic;
        if (go) begin
            priority if (last) begin
                n_ir = '0;
                n_ic = '0;
            end else if (col_wrap) begin
                n_ic = '0;
                n_ir = r_ir + 17'd1;
            end else begin
                n_ic = r_ic + CW'(1);
            end
        end
    end

    // line store column: bit0 older row, bit1 newer row
    cas_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (f_move),
        .i_waddr (r_f_slot),
        .i_wdata (wdata),
        .i_re    (go),
        .i_raddr (r_ic),
        .o_rdata (ram_rd)
    );

    // same column written and read in one cycle for a one-cell row or the first cell after a pass
    assign line  = r_f_byp ? r_f_bypd : ram_rd;
    assign f_top = r_f_ftop | line[0];
    assign f_mid = r_f_fmid | line[1];
    assign wdata = {r_f_bot, f_mid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
            r_ir    <= '0;
            r_ic    <= '0;
        end else begin
            r_ir <= n_ir;
            r_ic <= n_ic;
            if (go) begin
                r_f_vld <= 1'b1;
            end else if (f_move) begin
                r_f_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_f_slot <= r_ic;
            r_f_ftop <= !ir_ge2;
            r_f_fmid <= !ir_ge1;
            r_f_bot  <= in_grid ? i_cell_is_water : 1'b1;
            r_f_emit <= emit;
            r_f_ic0  <= ic_zero;
            r_f_cc0  <= cc == '0;
            r_f_last <= last;
            r_f_row  <= cr[ROW_W-1:0];
            r_f_col  <= cc_ext[COL_W-1:0];
            r_f_byp  <= f_move && (r_f_slot == r_ic);
            r_f_bypd <= wdata;
        end
    end

    assign o_q_push = f_move;
    always_comb begin
        o_q_op          = '0;
        o_q_op.col_bits = {r_f_bot, f_mid, f_top};
        o_q_op.emit     = r_f_emit;
        o_q_op.ic_zero  = r_f_ic0;
        o_q_op.cc_zero  = r_f_cc0;
        o_q_op.last     = r_f_last;
        o_q_op.row      = r_f_row;
        o_q_op.col      = r_f_col;
    end

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && last |=> r_ir == '0 && r_ic == '0)
        else $error("scan counters not cleared after the final cell");

    a_blocked_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_vld && i_q_full |=> r_f_vld)
        else $error("front entry lost while the queue was full");

endmodule

>>> rtl/cas_queue.sv
// two-entry queue between the front end and the back end
module cas_queue import cas_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    output logic o_vld,
    output t_op  o_op,
    input  logic i_pop
);

    t_op        r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt, n_cnt;

    assign o_full = r_cnt == 2'd2;
    assign o_vld  = r_cnt != 2'd0;
    assign o_op   = r_mem[r_rd];
    assign n_cnt  = r_cnt + {1'b0, i_push} - {1'b0, i_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full |-> !i_push) and (!o_vld |-> !i_pop))
        else $error("queue pushed when full or popped when empty");

endmodule

>>> rtl/cas_back.sv
// back end: 3x3 window, neighbour count and result register
module cas_back import cas_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_vld,
    input  t_op              i_q_op,
    output logic             o_pop,
    input  logic [3:0]       i_threshold,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_new_is_water,
    output logic [ROW_W-1:0] o_out_row,
    output logic [COL_W-1:0] o_out_col,
    output logic             o_last_cell
);

    logic [8:0]       r_win, win_n;
    logic [3:0]       cnt;
    logic             can;
    logic             r_o_vld;
    logic             r_o_water;
    logic [ROW_W-1:0] r_o_row;
    logic [COL_W-1:0] r_o_col;
    logic             r_o_last;

    function automatic logic [3:0] ones3(input logic [2:0] v);
        return {3'd0, v[0]} + {3'd0, v[1]} + {3'd0, v[2]};
    endfunction

    // left column, centre column without the cell itself, right column
    assign win_n = {i_q_op.col_bits, r_win[8:3]};
    assign cnt   = {3'd0, win_n[3]} + {3'd0, win_n[5]}
                 + (i_q_op.cc_zero ? 4'd3 : ones3(win_n[2:0]))
                 + (i_q_op.ic_zero ? 4'd3 : ones3(win_n[8:6]));

    // cells with no result never wait on the output side
    assign can   = !i_q_op.emit || !r_o_vld || !i_stall;
    assign o_pop = i_q_vld && can;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= '0;
            r_o_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_win <= i_q_op.last ? 9'd0 : win_n;
            end
            if (o_pop && i_q_op.emit) begin
                r_o_vld <= 1'b1;
            end else if (!i_stall) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_op.emit) begin
            r_o_water <= cnt > i_threshold;
            r_o_row   <= i_q_op.row;
            r_o_col   <= i_q_op.col;
            r_o_last  <= i_q_op.last;
        end
    end

    assign o_valid        = r_o_vld;
    assign o_new_is_water = r_o_water;
    assign o_out_row      = r_o_row;
    assign o_out_col      = r_o_col;
    assign o_last_cell    = r_o_last;

    a_window_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_q_op.last |=> r_win == '0)
        else $error("window not cleared at the end of the pass");

endmodule

>>> rtl/cave_automaton_smoothing_step.sv
// top level of the cave automaton smoothing step: config registers and block wiring
//
// Cells enter on the input channel (i_valid / o_stall) in raster order, one per
// transaction; i_func low pushes a cell, high is a flush tick that drains the
// final row once the grid has ended (flush ticks inside the grid are dropped).
// Each pushed cell or useful flush yields at most one result on the output
// channel (o_valid / i_stall): the next-generation cell with its row, column
// and a last-cell flag. Results trail the input by one grid row plus one cell.
// Throughput is one transaction per clock while o_stall is low; the front end takes
// a cell every such cycle, reading the line store column through a registered ram
// port, and a two-entry queue feeds the back end that shifts the 3x3 window.
// A result passes the front entry register and the queue before it is registered.
// When the receiver stalls, the result register holds, the queue fills and then
// o_stall rises; cells that give no result keep flowing past a held result.
// Reset clears the scan counters, window and queue and loads width 100,
// height 100, threshold 5; the line store needs no clearing.
// Configuration writes are always ready and take effect at once; write them only
// while no pass is in progress.
module cave_automaton_smoothing_step import cas_pkg::*; #(
    parameter int MAX_WIDTH = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_func,
    input  logic             i_cell_is_water,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_new_is_water,
    output logic [ROW_W-1:0] o_out_row,
    output logic [COL_W-1:0] o_out_col,
    output logic             o_last_cell,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data
);

    localparam logic [7:0]  RST_WIDTH     = 8'd100;
    localparam logic [15:0] RST_HEIGHT    = 16'd100;
    localparam logic [3:0]  RST_THRESHOLD = 4'd5;

    logic [7:0]  r_grid_width;
    logic [15:0] r_grid_height;
    logic [3:0]  r_threshold;

    logic q_full, q_push, q_vld, q_pop;
    t_op  q_in, q_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= RST_WIDTH;
            r_grid_height <= RST_HEIGHT;
            r_threshold   <= RST_THRESHOLD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH:         r_grid_width  <= i_cfg_data[7:0];
                CFG_GRID_HEIGHT:        r_grid_height <= i_cfg_data;
                CFG_NEIGHBOR_THRESHOLD: r_threshold   <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    cas_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_func          (i_func),
        .i_cell_is_water (i_cell_is_water),
        .o_stall         (o_stall),
        .i_grid_width    (r_grid_width),
        .i_grid_height   (r_grid_height),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_op          (q_in)
    );

    cas_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_op    (q_out),
        .i_pop   (q_pop)
    );

    cas_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_vld        (q_vld),
        .i_q_op         (q_out),
        .o_pop          (q_pop),
        .i_threshold    (r_threshold),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_new_is_water (o_new_is_water),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_last_cell    (o_last_cell)
    );

endmodule
